@@ src/dbtr_pkg.sv @@
// Shared types and constants for the double-byte aware token replacer.
// Used by every module under src; no dependencies of its own.
`timescale 1ns / 1ps

package dbtr_pkg;

  // Configuration bus
  localparam int unsigned CFG_ADDR_W = 6;
  localparam int unsigned CFG_DATA_W = 64;

  // Register indexes (paddr[5:3])
  localparam logic [2:0] REG_TOKEN_BYTES = 3'd0;
  localparam logic [2:0] REG_TOKEN_LEN   = 3'd1;
  localparam logic [2:0] REG_REPL_BYTES  = 3'd2;
  localparam logic [2:0] REG_REPL_LEN    = 3'd3;
  localparam logic [2:0] REG_LEAD1_LO    = 3'd4;
  localparam logic [2:0] REG_LEAD1_HI    = 3'd5;
  localparam logic [2:0] REG_LEAD2_LO    = 3'd6;
  localparam logic [2:0] REG_LEAD2_HI    = 3'd7;

  // Register reset values
  localparam logic [7:0] LEAD1_LO_RST = 8'd129;
  localparam logic [7:0] LEAD1_HI_RST = 8'd159;
  localparam logic [7:0] LEAD2_LO_RST = 8'd224;
  localparam logic [7:0] LEAD2_HI_RST = 8'd252;

  // Longest replacement in bytes
  localparam logic [3:0] REPL_MAX = 4'd8;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified source byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       lead;
  } item_t;

  // Request from the scanner to the output stage
  typedef struct packed {
    logic       push;   // new output byte
    logic       flush;  // string end: release held byte marked last
    logic [7:0] data;
  } emit_req_t;

endpackage

@@ src/dbtr_front.sv @@
// Input stage: registers the incoming byte and tags double-byte lead bytes.
// Depends on dbtr_pkg (item_t).
`timescale 1ns / 1ps

module dbtr_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     in_byte_i,
  input  logic           in_last_i,
  input  logic [7:0]     lead1_lo_i,
  input  logic [7:0]     lead1_hi_i,
  input  logic [7:0]     lead2_lo_i,
  input  logic [7:0]     lead2_hi_i,
  input  logic           fifo_full_i,
  output logic           push_o,
  output dbtr_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  dbtr_pkg::item_t item_q;
  logic            accept;
  logic            is_lead;

  assign in_stall_o = valid_q && fifo_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !fifo_full_i;
  assign item_o     = item_q;

  // Either inclusive range marks a lead byte; an empty range matches nothing
  assign is_lead = ((in_byte_i >= lead1_lo_i) && (in_byte_i <= lead1_hi_i)) ||
                   ((in_byte_i >= lead2_lo_i) && (in_byte_i <= lead2_hi_i));

  always_comb begin
    valid_d = accept || (valid_q && fifo_full_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data <= in_byte_i;
      item_q.last <= in_last_i;
      item_q.lead <= is_lead;
    end
  end

endmodule

@@ src/dbtr_fifo.sv @@
// Short queue of classified bytes between the input stage and the scanner.
// Depends on dbtr_pkg (item_t, QUEUE_DEPTH, QPTR_W).
`timescale 1ns / 1ps

module dbtr_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dbtr_pkg::item_t push_item_i,
  output logic            full_o,
  output logic            valid_o,
  output dbtr_pkg::item_t head_o,
  input  logic            pop_i
);

  dbtr_pkg::item_t            mem_q [dbtr_pkg::QUEUE_DEPTH];
  logic [dbtr_pkg::QPTR_W-1:0] wptr_q, rptr_q;
  logic [dbtr_pkg::QPTR_W:0]   cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign full_o  = (cnt_q == (dbtr_pkg::QPTR_W+1)'(dbtr_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

@@ src/dbtr_back.sv @@
// Scanner: holds the match window, compares it with the token and issues
// output bytes at most one per cycle, while the output stage is ready. Depends on dbtr_pkg (item_t, emit_req_t).
`timescale 1ns / 1ps

module dbtr_back #(
  parameter int unsigned TOKEN_MAX = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fifo_valid_i,
  input  dbtr_pkg::item_t     fifo_item_i,
  output logic                fifo_pop_o,
  input  logic [63:0]         token_bytes_i,
  input  logic [3:0]          token_length_i,
  input  logic [63:0]         repl_bytes_i,
  input  logic [3:0]          repl_length_i,
  input  logic                emit_ready_i,
  output dbtr_pkg::emit_req_t emit_req_o
);

  localparam int unsigned CW = $clog2(TOKEN_MAX + 1);
  localparam int unsigned IW = (TOKEN_MAX > 1) ? $clog2(TOKEN_MAX) : 1;

  logic [7:0]           win_q [TOKEN_MAX];
  logic [7:0]           win_d [TOKEN_MAX];
  logic [TOKEN_MAX-1:0] lead_q, lead_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        len_q, len_d;
  logic                 skip_q, skip_d;
  logic                 busy_q, busy_d;
  logic                 repl_q, repl_d;
  logic                 last_q, last_d;
  logic [2:0]           ridx_q, ridx_d;

  logic [CW-1:0] tok_len_sat;
  logic [3:0]    rlen;
  logic          done;
  logic          match;
  logic          take;
  logic          drop_en;
  logic [CW-1:0] drop_n;

  assign tok_len_sat = (token_length_i > 4'(TOKEN_MAX)) ? CW'(TOKEN_MAX)
                                                        : CW'(token_length_i);
  assign rlen = (repl_length_i > dbtr_pkg::REPL_MAX) ? dbtr_pkg::REPL_MAX
                                                     : repl_length_i;

  // Scan of the current byte is over: window empty, or too short to decide
  assign done = (count_q == '0) ||
                (!skip_q && (len_q != '0) && (count_q < len_q) && !last_q);

  always_comb begin
    match = (len_q != '0) && (count_q >= len_q);
    for (int i = 0; i < TOKEN_MAX; i++) begin
      if ((CW'(i) < len_q) && (win_q[i] != token_bytes_i[8*i +: 8])) begin
        match = 1'b0;
      end
    end
  end

  // Sequencer
  always_comb begin
    count_d    = count_q;
    len_d      = len_q;
    skip_d     = skip_q;
    busy_d     = busy_q;
    repl_d     = repl_q;
    last_d     = last_q;
    ridx_d     = ridx_q;
    take       = 1'b0;
    drop_en    = 1'b0;
    drop_n     = '0;
    emit_req_o = '0;

    if (!busy_q) begin
      take = fifo_valid_i;
    end else if (repl_q) begin
      if (emit_ready_i) begin
        emit_req_o.push = 1'b1;
        emit_req_o.data = repl_bytes_i[{ridx_q, 3'b000} +: 8];
        if ({1'b0, ridx_q} == rlen - 4'd1) begin
          repl_d  = 1'b0;
          drop_en = 1'b1;
          drop_n  = len_q;
        end else begin
          ridx_d = ridx_q + 3'd1;
        end
      end
    end else if (done) begin
      if (last_q) begin
        emit_req_o.flush = emit_ready_i;
      end
      if (!last_q || emit_ready_i) begin
        if (last_q) begin
          skip_d = 1'b0;
        end
        take   = fifo_valid_i;
        busy_d = fifo_valid_i;
      end
    end else if (skip_q) begin
      // trail byte of a double-byte pair never starts a match
      if (emit_ready_i) begin
        emit_req_o.push = 1'b1;
        emit_req_o.data = win_q[0];
        drop_en         = 1'b1;
        drop_n          = CW'(1);
        skip_d          = 1'b0;
      end
    end else if (match) begin
      if (rlen == '0) begin
        drop_en = 1'b1;
        drop_n  = len_q;
      end else begin
        repl_d = 1'b1;
        ridx_d = '0;
      end
    end else begin
      if (emit_ready_i) begin
        emit_req_o.push = 1'b1;
        emit_req_o.data = win_q[0];
        drop_en         = 1'b1;
        drop_n          = CW'(1);
        skip_d          = lead_q[0];
      end
    end

    if (drop_en) begin
      count_d = count_q - drop_n;
    end

    if (take) begin
      busy_d  = 1'b1;
      count_d = count_q + CW'(1);
      last_d  = fifo_item_i.last;
      if (count_q == '0) begin
        len_d = tok_len_sat;
      end
    end
  end

  assign fifo_pop_o = take;

  // Window shift and append
  always_comb begin
    logic [CW:0] src;
    src = '0;
    for (int i = 0; i < TOKEN_MAX; i++) begin
      win_d[i]  = win_q[i];
      lead_d[i] = lead_q[i];
      src = (CW+1)'(i) + {1'b0, drop_n};
      if (drop_en && (src < (CW+1)'(TOKEN_MAX))) begin
        win_d[i]  = win_q[src[IW-1:0]];
        lead_d[i] = lead_q[src[IW-1:0]];
      end
    end
    if (take) begin
      win_d[count_q[IW-1:0]]  = fifo_item_i.data;
      lead_d[count_q[IW-1:0]] = fifo_item_i.lead;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      len_q   <= '0;
      skip_q  <= 1'b0;
      busy_q  <= 1'b0;
      repl_q  <= 1'b0;
      last_q  <= 1'b0;
      ridx_q  <= '0;
    end else begin
      count_q <= count_d;
      len_q   <= len_d;
      skip_q  <= skip_d;
      busy_q  <= busy_d;
      repl_q  <= repl_d;
      last_q  <= last_d;
      ridx_q  <= ridx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    lead_q <= lead_d;
  end

endmodule

@@ src/dbtr_emit.sv @@
// Output stage: holds back the newest byte so the string end can be marked,
// then registers it toward the receiver. Depends on dbtr_pkg (emit_req_t).
`timescale 1ns / 1ps

module dbtr_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dbtr_pkg::emit_req_t req_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o
);

  logic       hold_valid_q, hold_valid_d;
  logic [7:0] hold_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       out_free;
  logic       load;

  assign out_free = !out_valid_q || !out_stall_i;
  assign ready_o  = !hold_valid_q || out_free;
  assign load     = (req_i.push || req_i.flush) && hold_valid_q && out_free;

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (req_i.push && ready_o) begin
      hold_valid_d = 1'b1;
    end else if (req_i.flush && ready_o) begin
      hold_valid_d = 1'b0;
    end
    out_valid_d = load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push && ready_o) begin
      hold_q <= req_i.data;
    end
    if (load) begin
      out_byte_q <= hold_q;
      out_last_q <= req_i.flush;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

@@ src/dbcs_token_replace.sv @@
// Top level of the double-byte aware token find-and-replace block.
// Depends on dbtr_pkg, dbtr_front, dbtr_fifo, dbtr_back and dbtr_emit.
`timescale 1ns / 1ps

// Usage
//   Input channel: in_valid_i / in_stall_o carry one source byte per request
//   with in_last_i set on the final byte of a string. Output channel:
//   out_valid_o / out_stall_i carry the rewritten bytes, out_last_o set on
//   the final byte of each rewritten string (an empty result shows nothing).
//   Registers are written over the APB port (8-byte stride); the user must
//   do so only while idle, as the block itself does not enforce it.
// Throughput
//   Pass-through bytes are loaded into the scanner's window, then emitted
//   from it. A token match emits its replacement at one byte per cycle
//   while the output stage is ready, or drops the token if the replacement
//   is empty. The scanner's single output port limits the rate, and a
//   4-entry queue lets input keep flowing while a replacement bursts out.
// Output hold-back
//   A byte reaches out_valid_o only once the next output byte is issued or
//   the string end is scanned.
// Reset and stall
//   Reset empties the queue, window and output stage and loads register
//   defaults. A stalled output holds its byte; the back-up then fills the
//   queue and raises in_stall_o.
module dbcs_token_replace #(
  parameter int unsigned TOKEN_MAX = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // source stream
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  // rewritten stream
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dbtr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [dbtr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [dbtr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  // Configuration registers
  logic [63:0] token_bytes_q;
  logic [3:0]  token_len_q;
  logic [63:0] repl_bytes_q;
  logic [3:0]  repl_len_q;
  logic [7:0]  lead1_lo_q, lead1_hi_q, lead2_lo_q, lead2_hi_q;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_bytes_q <= '0;
      token_len_q   <= '0;
      repl_bytes_q  <= '0;
      repl_len_q    <= '0;
      lead1_lo_q    <= dbtr_pkg::LEAD1_LO_RST;
      lead1_hi_q    <= dbtr_pkg::LEAD1_HI_RST;
      lead2_lo_q    <= dbtr_pkg::LEAD2_LO_RST;
      lead2_hi_q    <= dbtr_pkg::LEAD2_HI_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        dbtr_pkg::REG_TOKEN_BYTES: token_bytes_q <= pwdata;
        dbtr_pkg::REG_TOKEN_LEN:   token_len_q   <= pwdata[3:0];
        dbtr_pkg::REG_REPL_BYTES:  repl_bytes_q  <= pwdata;
        dbtr_pkg::REG_REPL_LEN:    repl_len_q    <= pwdata[3:0];
        dbtr_pkg::REG_LEAD1_LO:    lead1_lo_q    <= pwdata[7:0];
        dbtr_pkg::REG_LEAD1_HI:    lead1_hi_q    <= pwdata[7:0];
        dbtr_pkg::REG_LEAD2_LO:    lead2_lo_q    <= pwdata[7:0];
        dbtr_pkg::REG_LEAD2_HI:    lead2_hi_q    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back, zero-extended
  always_comb begin
    case (reg_idx)
      dbtr_pkg::REG_TOKEN_BYTES: prdata = token_bytes_q;
      dbtr_pkg::REG_TOKEN_LEN:   prdata = 64'(token_len_q);
      dbtr_pkg::REG_REPL_BYTES:  prdata = repl_bytes_q;
      dbtr_pkg::REG_REPL_LEN:    prdata = 64'(repl_len_q);
      dbtr_pkg::REG_LEAD1_LO:    prdata = 64'(lead1_lo_q);
      dbtr_pkg::REG_LEAD1_HI:    prdata = 64'(lead1_hi_q);
      dbtr_pkg::REG_LEAD2_LO:    prdata = 64'(lead2_lo_q);
      dbtr_pkg::REG_LEAD2_HI:    prdata = 64'(lead2_hi_q);
      default:                   prdata = '0;
    endcase
  end

  // Front: register and classify each source byte
  logic                fifo_full;
  logic                fifo_push;
  dbtr_pkg::item_t     front_item;

  dbtr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .lead1_lo_i  (lead1_lo_q),
    .lead1_hi_i  (lead1_hi_q),
    .lead2_lo_i  (lead2_lo_q),
    .lead2_hi_i  (lead2_hi_q),
    .fifo_full_i (fifo_full),
    .push_o      (fifo_push),
    .item_o      (front_item)
  );

  // Queue: decouple input acceptance from replacement bursts
  logic                fifo_valid;
  logic                fifo_pop;
  dbtr_pkg::item_t     fifo_head;

  dbtr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_item_i (front_item),
    .full_o      (fifo_full),
    .valid_o     (fifo_valid),
    .head_o      (fifo_head),
    .pop_i       (fifo_pop)
  );

  // Back: window compare and emission sequencing
  logic                emit_ready;
  dbtr_pkg::emit_req_t emit_req;

  dbtr_back #(
    .TOKEN_MAX (TOKEN_MAX)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fifo_valid_i   (fifo_valid),
    .fifo_item_i    (fifo_head),
    .fifo_pop_o     (fifo_pop),
    .token_bytes_i  (token_bytes_q),
    .token_length_i (token_len_q),
    .repl_bytes_i   (repl_bytes_q),
    .repl_length_i  (repl_len_q),
    .emit_ready_i   (emit_ready),
    .emit_req_o     (emit_req)
  );

  // Output: hold one byte back, mark string end, drive the receiver
  dbtr_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (emit_req),
    .ready_o     (emit_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

@@ verif/dbcs_token_replace_checker.sv @@
// Scoreboard for dbcs_token_replace: watches both byte channels and the APB port.
// Predicts the rewritten stream bit for bit and compares it. Depends on dbtr_pkg.
`timescale 1ns / 1ps

module dbcs_token_replace_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [7:0]                      in_byte_i,
  input  logic                            in_last_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [7:0]                      out_byte_i,
  input  logic                            out_last_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic                            pready_i,
  input  logic [dbtr_pkg::CFG_ADDR_W-1:0] paddr_i,
  input  logic [dbtr_pkg::CFG_DATA_W-1:0] pwdata_i,
  output int                              err_count_o,
  output int                              expected_left_o
);

  // register shadow
  logic [63:0] cfg_tok;
  logic [3:0]  cfg_tok_len;
  logic [63:0] cfg_rep;
  logic [3:0]  cfg_rep_len;
  logic [7:0]  cfg_lo1, cfg_hi1, cfg_lo2, cfg_hi2;

  // scan state
  logic [7:0] win [8];
  int         win_fill;
  logic       skip_trail;
  int         scan_len;
  logic       held_ok;
  logic [7:0] held_byte;

  // expected {byte, last}, oldest first
  logic [8:0] rewritten_q [$];
  logic [8:0] want;
  int         n_err;

  function automatic logic is_lead(input logic [7:0] b);
    return (b >= cfg_lo1 && b <= cfg_hi1) || (b >= cfg_lo2 && b <= cfg_hi2);
  endfunction

  function automatic logic token_hit(input int n);
    for (int i = 0; i < n; i++)
      if (win[i] != cfg_tok[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // One byte of lag: release the held byte, hold the new one.
  task automatic stage_byte(input logic [7:0] b);
    if (held_ok) rewritten_q.push_back({held_byte, 1'b0});
    held_byte = b;
    held_ok   = 1'b1;
  endtask

  task automatic drop_bytes(input int k);
    for (int i = 0; i + k < win_fill; i++) win[i] = win[i + k];
    win_fill -= k;
  endtask

  task automatic rewrite_byte(input logic [7:0] b, input logic last);
    int         n_tok;
    int         n_rep;
    logic [7:0] first;
    logic       done;
    // token length is latched only when the window is empty
    if (win_fill == 0) scan_len = (cfg_tok_len > 4'd8) ? 8 : int'(cfg_tok_len);
    n_tok = scan_len;
    n_rep = (cfg_rep_len > 4'd8) ? 8 : int'(cfg_rep_len);
    if (win_fill >= 8) begin
      stage_byte(win[0]);
      drop_bytes(1);
    end
    win[win_fill] = b;
    win_fill++;
    done = 1'b0;
    while (win_fill > 0 && !done) begin
      if (skip_trail) begin
        stage_byte(win[0]);
        drop_bytes(1);
        skip_trail = 1'b0;
      end else if (n_tok > 0 && win_fill < n_tok && !last) begin
        done = 1'b1;
      end else if (n_tok > 0 && win_fill >= n_tok && token_hit(n_tok)) begin
        for (int i = 0; i < n_rep; i++) stage_byte(cfg_rep[8*i +: 8]);
        drop_bytes(n_tok);
      end else begin
        first = win[0];
        stage_byte(first);
        drop_bytes(1);
        if (is_lead(first)) skip_trail = 1'b1;
      end
    end
    if (last) begin
      skip_trail = 1'b0;
      win_fill   = 0;
      if (held_ok) begin
        rewritten_q.push_back({held_byte, 1'b1});
        held_ok = 1'b0;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cfg_tok     = '0;
      cfg_tok_len = '0;
      cfg_rep     = '0;
      cfg_rep_len = '0;
      cfg_lo1     = dbtr_pkg::LEAD1_LO_RST;
      cfg_hi1     = dbtr_pkg::LEAD1_HI_RST;
      cfg_lo2     = dbtr_pkg::LEAD2_LO_RST;
      cfg_hi2     = dbtr_pkg::LEAD2_HI_RST;
      win_fill    = 0;
      skip_trail  = 1'b0;
      scan_len    = 0;
      held_ok     = 1'b0;
      held_byte   = '0;
      n_err       = 0;
      rewritten_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[dbtr_pkg::CFG_ADDR_W-1:3])
          dbtr_pkg::REG_TOKEN_BYTES: cfg_tok     = pwdata_i;
          dbtr_pkg::REG_TOKEN_LEN:   cfg_tok_len = pwdata_i[3:0];
          dbtr_pkg::REG_REPL_BYTES:  cfg_rep     = pwdata_i;
          dbtr_pkg::REG_REPL_LEN:    cfg_rep_len = pwdata_i[3:0];
          dbtr_pkg::REG_LEAD1_LO:    cfg_lo1     = pwdata_i[7:0];
          dbtr_pkg::REG_LEAD1_HI:    cfg_hi1     = pwdata_i[7:0];
          dbtr_pkg::REG_LEAD2_LO:    cfg_lo2     = pwdata_i[7:0];
          dbtr_pkg::REG_LEAD2_HI:    cfg_hi2     = pwdata_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) rewrite_byte(in_byte_i, in_last_i);
      if (out_valid_i && !out_stall_i) begin
        if (rewritten_q.size() == 0) begin
          if (n_err < 10)
            $display("%0t: unexpected output byte %02h last %0b", $realtime,
                     out_byte_i, out_last_i);
          n_err++;
        end else begin
          want = rewritten_q.pop_front();
          if (want[8:1] != out_byte_i || want[0] != out_last_i) begin
            if (n_err < 10)
              $display("%0t: output byte expected %02h last %0b, got %02h last %0b",
                       $realtime, want[8:1], want[0], out_byte_i, out_last_i);
            n_err++;
          end
        end
      end
    end
    err_count_o     <= n_err;
    expected_left_o <= rewritten_q.size();
  end

endmodule

@@ verif/dbcs_token_replace_test.sv @@
// Stimulus and verdict for dbcs_token_replace: APB setup, byte strings, idling.
// Depends on dbtr_pkg, the block under src and dbcs_token_replace_checker.
`timescale 1ns / 1ps

module dbcs_token_replace_test;

  localparam int SETTLE_CYCLES = 32;      // pipeline slack after the last result
  localparam int RUN_LIMIT     = 400000;  // cycles before the run is declared hung
  localparam int BATCH_ITEMS   = 18;      // minimum random requests per setting

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [7:0]                      in_byte = '0;
  logic                            in_last = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [7:0]                      out_byte;
  logic                            out_last;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [dbtr_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [dbtr_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [dbtr_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  int err_count;
  int expected_left;

  // idling percentages, set per phase
  int src_idle  = 0;
  int sink_stall = 0;

  // copy of the settings in force, used to shape the strings
  logic [63:0] cur_tok;
  logic [3:0]  cur_tok_len;
  logic [7:0]  cur_lo1, cur_hi1;

  dbcs_token_replace DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_byte_i   (in_byte),
    .in_last_i   (in_last),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .out_last_o  (out_last),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  dbcs_token_replace_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_byte_i       (in_byte),
    .in_last_i       (in_last),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_byte_i      (out_byte),
    .out_last_i      (out_last),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .err_count_o     (err_count),
    .expected_left_o (expected_left)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Receiver back-pressure: redraw the stall every cycle.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < sink_stall);
  end

  // Watchdog: declare the run hung once the limit is reached.
  initial begin
    repeat (RUN_LIMIT) @(posedge clk_i);
    $display("dbcs_token_replace: mismatch");
    $finish;
  end

  // Write one register: setup phase, then access phase until pready.
  // The bus stays selected so another write can follow at once.
  task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // Write every register and remember what the strings should aim at.
  task automatic set_config(input logic [63:0] tok, input logic [3:0] tok_len,
                            input logic [63:0] rep, input logic [3:0] rep_len,
                            input logic [7:0] lo1, input logic [7:0] hi1,
                            input logic [7:0] lo2, input logic [7:0] hi2);
    apb_write(dbtr_pkg::REG_TOKEN_BYTES, tok);
    apb_write(dbtr_pkg::REG_TOKEN_LEN,   {60'd0, tok_len});
    apb_write(dbtr_pkg::REG_REPL_BYTES,  rep);
    apb_write(dbtr_pkg::REG_REPL_LEN,    {60'd0, rep_len});
    apb_write(dbtr_pkg::REG_LEAD1_LO,    {56'd0, lo1});
    apb_write(dbtr_pkg::REG_LEAD1_HI,    {56'd0, hi1});
    apb_write(dbtr_pkg::REG_LEAD2_LO,    {56'd0, lo2});
    apb_write(dbtr_pkg::REG_LEAD2_HI,    {56'd0, hi2});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_tok     = tok;
    cur_tok_len = tok_len;
    cur_lo1     = lo1;
    cur_hi1     = hi1;
  endtask

  // Offer one request, idling first at the sender's rate; return once accepted.
  // Keep valid high across back-to-back requests so it is never dropped and
  // raised in the same step.
  task automatic send_req(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Send n bytes taken low byte first from v, the final one marked last.
  task automatic send_packed(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) send_req(v[8*i +: 8], i == n - 1);
  endtask

  // Build one string mostly from whole tokens, with partial tokens, lead
  // bytes, near misses and plain noise mixed in.
  task automatic send_random_string(output int n_sent);
    logic [7:0] str [64];
    int         n;
    int         tl;
    int         cut;
    n  = 0;
    tl = (cur_tok_len > 4'd8) ? 8 : int'(cur_tok_len);
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          for (int j = 0; j < tl; j++) str[n++] = cur_tok[8*j +: 8];
        end
        4: begin
          cut = $urandom_range(tl);
          for (int j = 0; j < cut; j++) str[n++] = cur_tok[8*j +: 8];
        end
        5: begin
          if (cur_lo1 <= cur_hi1) str[n++] = 8'($urandom_range(cur_hi1, cur_lo1));
          else str[n++] = 8'($urandom_range(255));
        end
        6: str[n++] = cur_tok[8*$urandom_range(7) +: 8];
        default: str[n++] = 8'($urandom_range(255));
      endcase
    end
    if (n == 0) str[n++] = 8'($urandom_range(255));
    for (int j = 0; j < n; j++) send_req(str[j], j == n - 1);
    n_sent = n;
  endtask

  // Hold the sender until every expected byte is out, then let the
  // pipeline settle so the block is idle for a register write.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_left != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int  batch;
    int  n_sent;
    bit  paused;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    cur_tok     = '0;
    cur_tok_len = '0;
    cur_lo1     = dbtr_pkg::LEAD1_LO_RST;
    cur_hi1     = dbtr_pkg::LEAD1_HI_RST;

    // Directed: reset settings pass data through; extreme bytes, and a lead
    // byte at the very end that has no trail.
    send_packed(64'h0000_0000_0000_FF00, 2);
    send_packed(64'h81, 1);
    drain();

    // Directed: two-byte token, three-byte replacement.
    set_config(64'h4241, 4'd2, 64'h7A7978, 4'd3,
               dbtr_pkg::LEAD1_LO_RST, dbtr_pkg::LEAD1_HI_RST,
               dbtr_pkg::LEAD2_LO_RST, dbtr_pkg::LEAD2_HI_RST);
    send_packed(64'h4241, 2);        // string that is exactly the token
    send_packed(64'h21424178, 4);    // token inside the string
    send_packed(64'h424181, 3);      // lead byte shields its trail from a match
    send_packed(64'h41, 1);          // short tail flushed unmatched
    send_packed(64'h42414241, 4);    // back-to-back tokens
    drain();

    // Directed: the oversized token length saturates, the replacement deletes,
    // both lead ranges empty; a string of one whole token leaves nothing.
    set_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'h0, 4'd0,
               8'd200, 8'd100, 8'd255, 8'd0);
    send_packed(64'hFFFF_FFFF_FFFF_FFFF, 8);
    drain();

    // Random: one setting per phase, idling rotating through the modes.
    paused = 1'b0;
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: set_config({$urandom, $urandom}, 4'd8, {$urandom, $urandom}, 4'd8,
                      dbtr_pkg::LEAD1_LO_RST, dbtr_pkg::LEAD1_HI_RST,
                      dbtr_pkg::LEAD2_LO_RST, dbtr_pkg::LEAD2_HI_RST);
        1: set_config(64'h0, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15,
                      8'd0, 8'd255, 8'd255, 8'd255);
        2: set_config({$urandom, $urandom}, 4'd3, {$urandom, $urandom}, 4'd0,
                      8'd0, 8'd0, 8'd255, 8'd1);
        3: set_config({$urandom, $urandom}, 4'd0, {$urandom, $urandom}, 4'd5,
                      dbtr_pkg::LEAD1_LO_RST, dbtr_pkg::LEAD1_HI_RST,
                      dbtr_pkg::LEAD2_LO_RST, dbtr_pkg::LEAD2_HI_RST);
        4: set_config(64'h4281_4181, 4'd4, {$urandom, $urandom}, 4'd2,
                      dbtr_pkg::LEAD1_LO_RST, dbtr_pkg::LEAD1_HI_RST,
                      dbtr_pkg::LEAD2_LO_RST, dbtr_pkg::LEAD2_HI_RST);
        default: set_config({$urandom, $urandom}, 4'd15, {$urandom, $urandom}, 4'd1,
                            8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), 8'($urandom_range(255)));
      endcase
      case (s % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 68; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 68; end
        default: begin src_idle = 35; sink_stall = 35; end
      endcase
      batch = 0;
      while (batch < BATCH_ITEMS) begin
        send_random_string(n_sent);
        batch += n_sent;
        // Pause the sender once in phase 2 until the output has caught up.
        if (s == 2 && !paused) begin
          drain();
          paused = 1'b1;
        end
      end
      drain();
    end

    if (err_count == 0) begin
      $display("dbcs_token_replace: match");
    end else begin
      $display("dbcs_token_replace: mismatch");
    end
    $finish;
  end

endmodule
